// ----- hw/rtl/salc_pkg.sv -----
// Package with the constants, row layout and state codes of the set-associative LRU cache model.
package salc_pkg;

  localparam int unsigned MAX_SET_BITS = 8;
  localparam int unsigned MAX_WAYS     = 8;
  localparam int unsigned ADDRESS_BITS = 32;

  localparam int unsigned NUM_SETS   = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned RANK_W     = WAY_W;
  localparam int unsigned FILL_W     = $clog2(MAX_WAYS + 1);

  localparam int unsigned CFG_SB_W   = 4;
  localparam int unsigned CFG_WAYS_W = 4;
  localparam int unsigned CFG_BOB_W  = 5;
  localparam int unsigned SHIFT_W    = $clog2(MAX_SET_BITS + (1 << CFG_BOB_W));
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned CNT_W      = 32;

  localparam logic [CFG_SB_W-1:0]   SET_BITS_RESET    = 4'd4;
  localparam logic [CFG_WAYS_W-1:0] WAYS_RESET        = 4'd1;
  localparam logic [CFG_BOB_W-1:0]  OFFSET_BITS_RESET = 5'd4;

  typedef struct packed {
    logic [FILL_W-1:0]                      fill;
    logic [MAX_WAYS-1:0]                    valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]        rank;
    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0]  tag;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE,
    ST_EMIT
  } st_e;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_FETCH  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_SET_BITS    = 2'd0,
    REG_WAYS        = 2'd1,
    REG_OFFSET_BITS = 2'd2
  } reg_idx_e;

endpackage

// ----- hw/rtl/salc_ram.sv -----
// Generic single-port-write, registered-read RAM.
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/set_assoc_lru_cache_model.sv -----
// Set-associative cache model with true LRU replacement and hit, miss and eviction counters.
// Each set is one row of a RAM holding all tags, valid bits, recency ranks and the fill count
// of that set; a per-set valid flag in flip-flops makes a never-written row read as empty, so
// no clearing pass is needed after reset. A lookup reads the row, walks its eight ways through
// one tag comparator (one way per cycle), then writes the updated row back. A load or store
// beat gives one lookup and one result beat, a modify beat two of each, and an instruction fetch
// beat neither; no new beat is accepted until the last result has entered the output register.
module set_assoc_lru_cache_model import salc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              opcode_i,
  input  logic [ADDRESS_BITS-1:0] access_address_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o,
  output logic                    eviction_o,
  output logic                    last_o,
  output logic [CNT_W-1:0]        hit_total_o,
  output logic [CNT_W-1:0]        miss_total_o,
  output logic [CNT_W-1:0]        eviction_total_o
);

  st_e st_q, st_d;

  logic [CFG_SB_W-1:0]   set_bits_q;
  logic [CFG_WAYS_W-1:0] ways_q;
  logic [CFG_BOB_W-1:0]  offset_bits_q;
  logic                  cfg_we;

  logic [CFG_SB_W-1:0]     sb_eff;
  logic [FILL_W-1:0]       ways_eff;
  logic [ADDRESS_BITS-1:0] addr_off;
  logic [SET_W-1:0]        idx_mask;
  logic [SET_W-1:0]        set_in;
  logic [SHIFT_W-1:0]      tag_shift;
  logic [ADDRESS_BITS-1:0] tag_in;

  opcode_e                 op_q;
  logic                    second_q;
  logic [SET_W-1:0]        set_q;
  logic [ADDRESS_BITS-1:0] tag_q;
  logic [NUM_SETS-1:0]     row_valid_q;
  logic                    rowv_q;

  logic [WAY_W-1:0]  way_q;
  logic              found_q;
  logic [WAY_W-1:0]  hit_way_q;
  logic              inv_found_q;
  logic [WAY_W-1:0]  inv_way_q;
  logic              lru_any_q;
  logic [WAY_W-1:0]  lru_way_q;
  logic [RANK_W-1:0] lru_rank_q;

  logic [ROW_W-1:0]        ram_rdata;
  row_t                    row_cur;
  row_t                    row_new;
  logic                    ram_re;
  logic                    ram_we;
  logic                    cur_valid;
  logic [RANK_W-1:0]       cur_rank;
  logic [ADDRESS_BITS-1:0] cur_tag;
  logic [RANK_W-1:0]       hit_rank;
  logic                    room;
  logic [WAY_W-1:0]        victim;
  logic                    evict_now;

  logic [CNT_W-1:0] hit_cnt_q;
  logic [CNT_W-1:0] miss_cnt_q;
  logic [CNT_W-1:0] evict_cnt_q;
  logic             res_hit_q;
  logic             res_evict_q;

  logic             out_valid_q;
  logic             out_free;
  logic             out_load;
  logic             in_accept;
  logic             out_hit_q;
  logic             out_evict_q;
  logic             out_last_q;
  logic [CNT_W-1:0] out_hit_cnt_q;
  logic [CNT_W-1:0] out_miss_cnt_q;
  logic [CNT_W-1:0] out_evict_cnt_q;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= SET_BITS_RESET;
      ways_q        <= WAYS_RESET;
      offset_bits_q <= OFFSET_BITS_RESET;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_SET_BITS:    set_bits_q    <= pwdata[CFG_SB_W-1:0];
        REG_WAYS:        ways_q        <= pwdata[CFG_WAYS_W-1:0];
        REG_OFFSET_BITS: offset_bits_q <= pwdata[CFG_BOB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_SET_BITS:    prdata = APB_DATA_W'(set_bits_q);
      REG_WAYS:        prdata = APB_DATA_W'(ways_q);
      REG_OFFSET_BITS: prdata = APB_DATA_W'(offset_bits_q);
      default:         prdata = '0;
    endcase
  end

  // Address split.
  always_comb begin
    sb_eff    = (set_bits_q > CFG_SB_W'(MAX_SET_BITS)) ? CFG_SB_W'(MAX_SET_BITS) : set_bits_q;
    addr_off  = access_address_i >> offset_bits_q;
    idx_mask  = ~({SET_W{1'b1}} << sb_eff);
    set_in    = addr_off[SET_W-1:0] & idx_mask;
    tag_shift = SHIFT_W'(sb_eff) + SHIFT_W'(offset_bits_q);
    tag_in    = access_address_i >> tag_shift;
    if (ways_q == '0) begin
      ways_eff = FILL_W'(1);
    end else if (ways_q > CFG_WAYS_W'(MAX_WAYS)) begin
      ways_eff = FILL_W'(MAX_WAYS);
    end else begin
      ways_eff = FILL_W'(ways_q);
    end
  end

  // Sequencer: next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i && (opcode_e'(opcode_i) != OP_FETCH)) begin
          st_d = ST_READ;
        end
      end
      ST_READ: st_d = ST_SCAN;
      ST_SCAN: begin
        if (way_q == WAY_W'(MAX_WAYS - 1)) begin
          st_d = ST_WRITE;
        end
      end
      ST_WRITE: st_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          st_d = (op_q == OP_MODIFY && !second_q) ? ST_READ : ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall_o = (st_q != ST_IDLE);
    in_accept  = (st_q == ST_IDLE) && in_valid_i;
    ram_re     = (st_q == ST_READ);
    ram_we     = (st_q == ST_WRITE);
    out_free   = !out_valid_q || !out_stall_i;
    out_load   = (st_q == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_q),
    .wdata_i (row_new),
    .re_i    (ram_re),
    .raddr_i (set_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    row_cur = row_t'(ram_rdata);
    if (!rowv_q) begin
      row_cur.fill  = '0;
      row_cur.valid = '0;
      row_cur.rank  = '0;
    end
    cur_valid = row_cur.valid[way_q];
    cur_rank  = row_cur.rank[way_q];
    cur_tag   = row_cur.tag[way_q];
  end

  // Row update for the write-back.
  always_comb begin
    row_new   = row_cur;
    hit_rank  = row_cur.rank[hit_way_q];
    room      = row_cur.fill < ways_eff;
    victim    = room ? (inv_found_q ? inv_way_q : '0) : lru_way_q;
    evict_now = !found_q && !room;
    if (found_q) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (row_cur.valid[w] && row_cur.rank[w] < hit_rank) begin
          row_new.rank[w] = row_cur.rank[w] + RANK_W'(1);
        end
      end
      row_new.rank[hit_way_q] = '0;
    end else begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (row_cur.valid[w] && WAY_W'(w) != victim) begin
          row_new.rank[w] = row_cur.rank[w] + RANK_W'(1);
        end
      end
      row_new.valid[victim] = 1'b1;
      row_new.tag[victim]   = tag_q;
      row_new.rank[victim]  = '0;
      if (room) begin
        row_new.fill = row_cur.fill + FILL_W'(1);
      end
    end
  end

  // Lookup datapath.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= opcode_e'(opcode_i);
      set_q <= set_in;
      tag_q <= tag_in;
    end
    if (st_q == ST_READ) begin
      rowv_q      <= row_valid_q[set_q];
      found_q     <= 1'b0;
      hit_way_q   <= '0;
      inv_found_q <= 1'b0;
      inv_way_q   <= '0;
      lru_any_q   <= 1'b0;
      lru_way_q   <= '0;
      lru_rank_q  <= '0;
    end
    if (st_q == ST_SCAN) begin
      if (cur_valid && cur_tag == tag_q && !found_q) begin
        found_q   <= 1'b1;
        hit_way_q <= way_q;
      end
      if (!cur_valid && !inv_found_q) begin
        inv_found_q <= 1'b1;
        inv_way_q   <= way_q;
      end
      if (cur_valid && (!lru_any_q || cur_rank > lru_rank_q)) begin
        lru_any_q  <= 1'b1;
        lru_way_q  <= way_q;
        lru_rank_q <= cur_rank;
      end
    end
    if (st_q == ST_WRITE) begin
      res_hit_q   <= found_q;
      res_evict_q <= evict_now;
    end
    if (out_load) begin
      out_hit_q       <= res_hit_q;
      out_evict_q     <= res_evict_q;
      out_last_q      <= !(op_q == OP_MODIFY && !second_q);
      out_hit_cnt_q   <= hit_cnt_q;
      out_miss_cnt_q  <= miss_cnt_q;
      out_evict_cnt_q <= evict_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_q       <= '0;
      second_q    <= 1'b0;
      row_valid_q <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        second_q <= 1'b0;
      end
      if (st_q == ST_READ) begin
        way_q <= '0;
      end
      if (st_q == ST_SCAN) begin
        way_q <= way_q + WAY_W'(1);
      end
      if (st_q == ST_WRITE) begin
        row_valid_q[set_q] <= 1'b1;
        hit_cnt_q          <= hit_cnt_q + CNT_W'(found_q);
        miss_cnt_q         <= miss_cnt_q + CNT_W'(!found_q);
        evict_cnt_q        <= evict_cnt_q + CNT_W'(evict_now);
      end
      if (out_load && op_q == OP_MODIFY && !second_q) begin
        second_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_hit_q;
  assign eviction_o       = out_evict_q;
  assign last_o           = out_last_q;
  assign hit_total_o      = out_hit_cnt_q;
  assign miss_total_o     = out_miss_cnt_q;
  assign eviction_total_o = out_evict_cnt_q;

`ifndef SYNTHESIS
  a_one_lookup_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_WRITE |=>
      CNT_W'(hit_cnt_q + miss_cnt_q) == CNT_W'($past(hit_cnt_q) + $past(miss_cnt_q) + 1))
    else $error("A write-back must count exactly one hit or miss.");

  a_counters_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_WRITE |=>
      $stable(hit_cnt_q) && $stable(miss_cnt_q) && $stable(evict_cnt_q))
    else $error("Counters changed outside a write-back.");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WRITE && found_q) |=> evict_cnt_q == $past(evict_cnt_q))
    else $error("A hit must not count an eviction.");

  a_row_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_WRITE |=> row_valid_q[set_q])
    else $error("A written row must be marked valid.");

  a_held_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT && out_valid_q && out_stall_i) |=> st_q == ST_EMIT)
    else $error("A result must wait while the output beat is stalled.");
`endif

endmodule

// ----- sim/lru_lookup_checker.sv -----
// Checker that predicts every lookup beat of the LRU cache model and compares the output beats.
module lru_lookup_checker import salc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  input  logic                    in_valid_i,
  input  logic                    in_stall_o,
  input  logic [1:0]              opcode_i,
  input  logic [ADDRESS_BITS-1:0] access_address_i,
  input  logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic                    hit_o,
  input  logic                    eviction_o,
  input  logic                    last_o,
  input  logic [CNT_W-1:0]        hit_total_o,
  input  logic [CNT_W-1:0]        miss_total_o,
  input  logic [CNT_W-1:0]        eviction_total_o,
  output int                      mismatch_count_o,
  output int                      pending_o,
  output int                      beats_checked_o,
  output int                      hits_seen_o,
  output int                      evictions_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_LINES = NUM_SETS * MAX_WAYS;

  typedef struct packed {
    logic             hit;
    logic             eviction;
    logic             last;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } lookup_outcome_t;

  logic [ADDRESS_BITS-1:0] line_tag  [NUM_LINES];
  logic                    line_live [NUM_LINES];
  logic [RANK_W-1:0]       line_rank [NUM_LINES];
  logic [FILL_W-1:0]       set_count [NUM_SETS];
  logic [CNT_W-1:0]        hit_tally;
  logic [CNT_W-1:0]        miss_tally;
  logic [CNT_W-1:0]        evict_tally;
  logic [CFG_SB_W-1:0]     set_bits;
  logic [CFG_WAYS_W-1:0]   way_limit;
  logic [CFG_BOB_W-1:0]    offset_bits;

  lookup_outcome_t awaited_outcomes [$];
  int              fault_total;
  int              checked_total;
  int              hit_beats;
  int              evict_beats;

  function automatic lookup_outcome_t predict_lookup(logic [ADDRESS_BITS-1:0] addr);
    int unsigned       sb;
    int unsigned       ways;
    int unsigned       shift;
    int unsigned       set_idx;
    int unsigned       base;
    int unsigned       victim;
    int                found;
    logic [63:0]       wide;
    logic [63:0]       tag;
    logic [RANK_W-1:0] r;
    logic [RANK_W-1:0] best;
    logic              any;
    lookup_outcome_t   res;
    res = '0;
    sb = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : set_bits;
    ways = (way_limit == 0) ? 1 : way_limit;
    if (ways > MAX_WAYS) ways = MAX_WAYS;
    shift = sb + offset_bits;
    wide = 64'(addr);
    set_idx = int'((wide >> offset_bits) & ((64'd1 << sb) - 64'd1)) & (NUM_SETS - 1);
    tag = (shift >= 64) ? 64'd0 : (wide >> shift);
    base = set_idx * MAX_WAYS;
    found = -1;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (found < 0 && line_live[base + w] && line_tag[base + w] == tag[ADDRESS_BITS-1:0]) begin
        found = w;
      end
    end
    if (found >= 0) begin
      r = line_rank[base + found];
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (line_live[base + w] && line_rank[base + w] < r) line_rank[base + w]++;
      end
      line_rank[base + found] = '0;
      hit_tally++;
      res.hit = 1'b1;
    end else begin
      victim = 0;
      miss_tally++;
      if (set_count[set_idx] < ways) begin
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
          if (!line_live[base + w]) victim = w;
        end
        set_count[set_idx]++;
      end else begin
        best = '0;
        any = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
          if (line_live[base + w] && (!any || line_rank[base + w] > best)) begin
            best = line_rank[base + w];
            victim = w;
            any = 1'b1;
          end
        end
        line_live[base + victim] = 1'b0;
        evict_tally++;
        res.eviction = 1'b1;
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (line_live[base + w]) line_rank[base + w]++;
      end
      line_live[base + victim] = 1'b1;
      line_tag[base + victim] = tag[ADDRESS_BITS-1:0];
      line_rank[base + victim] = '0;
    end
    res.hit_total = hit_tally;
    res.miss_total = miss_tally;
    res.eviction_total = evict_tally;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lookup_outcome_t seen;
    lookup_outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        line_tag[i] = '0;
        line_live[i] = 1'b0;
        line_rank[i] = '0;
      end
      for (int i = 0; i < NUM_SETS; i++) set_count[i] = '0;
      hit_tally = '0;
      miss_tally = '0;
      evict_tally = '0;
      set_bits = SET_BITS_RESET;
      way_limit = WAYS_RESET;
      offset_bits = OFFSET_BITS_RESET;
      awaited_outcomes.delete();
      fault_total = 0;
      checked_total = 0;
      hit_beats = 0;
      evict_beats = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[APB_ADDR_W-1:2]))
          REG_SET_BITS:    set_bits = pwdata[CFG_SB_W-1:0];
          REG_WAYS:        way_limit = pwdata[CFG_WAYS_W-1:0];
          REG_OFFSET_BITS: offset_bits = pwdata[CFG_BOB_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        seen = {hit_o, eviction_o, last_o, hit_total_o, miss_total_o, eviction_total_o};
        if (awaited_outcomes.size() == 0) begin
          if (fault_total < 10) begin
            $display("Unexpected result beat: hit=%0b eviction=%0b last=%0b totals %0d/%0d/%0d",
                     seen.hit, seen.eviction, seen.last,
                     seen.hit_total, seen.miss_total, seen.eviction_total);
          end
          fault_total++;
        end else begin
          want = awaited_outcomes.pop_front();
          checked_total++;
          if (want.hit) hit_beats++;
          if (want.eviction) evict_beats++;
          if (seen !== want) begin
            if (fault_total < 10) begin
              $display("Mismatch on beat %0d: expected hit=%0b eviction=%0b last=%0b %0d/%0d/%0d",
                       checked_total, want.hit, want.eviction, want.last,
                       want.hit_total, want.miss_total, want.eviction_total);
              $display("                   actual hit=%0b eviction=%0b last=%0b %0d/%0d/%0d",
                       seen.hit, seen.eviction, seen.last,
                       seen.hit_total, seen.miss_total, seen.eviction_total);
            end
            fault_total++;
          end
        end
      end
      if (in_valid_i && !in_stall_o && opcode_e'(opcode_i) != OP_FETCH) begin
        want = predict_lookup(access_address_i);
        if (opcode_e'(opcode_i) == OP_MODIFY) begin
          awaited_outcomes.push_back(want);
          want = predict_lookup(access_address_i);
        end
        want.last = 1'b1;
        awaited_outcomes.push_back(want);
      end
    end
    mismatch_count_o <= fault_total;
    pending_o <= awaited_outcomes.size();
    beats_checked_o <= checked_total;
    hits_seen_o <= hit_beats;
    evictions_seen_o <= evict_beats;
  end

endmodule

// ----- sim/set_assoc_lru_cache_model_test.sv -----
// Top of the testbench for the LRU cache model: clock, reset, register writes and access beats.
module set_assoc_lru_cache_model_test;
  timeunit 1ns;
  timeprecision 1ps;
  import salc_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int NUM_PHASES    = 10;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              opcode_i = '0;
  logic [ADDRESS_BITS-1:0] access_address_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    hit_o;
  logic                    eviction_o;
  logic                    last_o;
  logic [CNT_W-1:0]        hit_total_o;
  logic [CNT_W-1:0]        miss_total_o;
  logic [CNT_W-1:0]        eviction_total_o;

  int mismatch_count;
  int pending;
  int beats_checked;
  int hits_seen;
  int evictions_seen;

  int send_idle_pct = 27;
  int recv_stall_pct = 73;
  int cycle_count = 0;
  int accesses_sent = 0;
  int fetches_sent = 0;
  int settings_used = 1;

  logic [ADDRESS_BITS-1:0] recent_addrs [$];

  int unsigned phase_set_bits [NUM_PHASES] = '{0, 8, 2, 2, 15, 9, 1, 3, 0, 4};
  int unsigned phase_ways     [NUM_PHASES] = '{8, 8, 8, 2, 0, 15, 3, 4, 1, 1};
  int unsigned phase_offset   [NUM_PHASES] = '{0, 24, 4, 4, 31, 2, 30, 6, 0, 4};
  int          phase_lookups  [NUM_PHASES] = '{150, 140, 150, 140, 130, 140, 130, 150, 120, 150};

  opcode_e probe_ops [16] = '{
    OP_LOAD, OP_LOAD, OP_STORE, OP_MODIFY, OP_FETCH, OP_LOAD, OP_STORE, OP_MODIFY,
    OP_LOAD, OP_FETCH, OP_FETCH, OP_STORE, OP_LOAD, OP_MODIFY, OP_MODIFY, OP_STORE
  };
  logic [ADDRESS_BITS-1:0] probe_addrs [16] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF,
    32'h1234_5678, 32'h0000_0100, 32'h0000_0000, 32'h0000_0100,
    32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF
  };

  set_assoc_lru_cache_model u_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .access_address_i,
    .out_valid_o,
    .out_stall_i,
    .hit_o,
    .eviction_o,
    .last_o,
    .hit_total_o,
    .miss_total_o,
    .eviction_total_o
  );

  lru_lookup_checker u_checker (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .pready,
    .paddr,
    .pwdata,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .access_address_i,
    .out_valid_o,
    .out_stall_i,
    .hit_o,
    .eviction_o,
    .last_o,
    .hit_total_o,
    .miss_total_o,
    .eviction_total_o,
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .beats_checked_o  (beats_checked),
    .hits_seen_o      (hits_seen),
    .evictions_seen_o (evictions_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic write_register(reg_idx_e idx, logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic issue_access(opcode_e op, logic [ADDRESS_BITS-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    access_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_FETCH) fetches_sent++;
    else accesses_sent++;
  endtask

  // Holds off new beats until every predicted result beat has been taken.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [ADDRESS_BITS-1:0] pick_address(int unsigned sb_raw,
                                                           int unsigned ways_raw,
                                                           int unsigned bob);
    int unsigned sb;
    int unsigned ways;
    int unsigned span;
    int unsigned set_sel;
    int unsigned tag_sel;
    logic [63:0] wide;
    sb = (sb_raw > MAX_SET_BITS) ? MAX_SET_BITS : sb_raw;
    ways = (ways_raw == 0) ? 1 : ((ways_raw > MAX_WAYS) ? MAX_WAYS : ways_raw);
    span = 1 << sb;
    if ($urandom_range(0, 9) == 0) set_sel = $urandom_range(0, span - 1);
    else set_sel = $urandom_range(0, ((span < 4) ? span : 4) - 1);
    tag_sel = $urandom_range(0, ways + 1);
    wide = (64'(tag_sel) << (sb + bob)) | (64'(set_sel) << bob)
         | (64'($urandom) & ((64'd1 << bob) - 64'd1));
    return wide[ADDRESS_BITS-1:0];
  endfunction

  initial begin
    int                      lookups_done;
    int                      roll;
    opcode_e                 op;
    logic [ADDRESS_BITS-1:0] addr;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 16; i++) issue_access(probe_ops[i], probe_addrs[i]);
    wait_for_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 27;
        recv_stall_pct = 73;
      end else if (p < 7) begin
        send_idle_pct = 73;
        recv_stall_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_register(REG_SET_BITS, phase_set_bits[p]);
      write_register(REG_WAYS, phase_ways[p]);
      write_register(REG_OFFSET_BITS, phase_offset[p]);
      settings_used++;
      recent_addrs.delete();
      lookups_done = 0;
      while (lookups_done < phase_lookups[p]) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) op = OP_LOAD;
        else if (roll < 60) op = OP_STORE;
        else if (roll < 85) op = OP_MODIFY;
        else op = OP_FETCH;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          addr = pick_address(phase_set_bits[p], phase_ways[p], phase_offset[p]);
        end else if (roll < 80 && recent_addrs.size() != 0) begin
          addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        end else begin
          addr = $urandom;
        end
        issue_access(op, addr);
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
        lookups_done++;
      end
      wait_for_results();
    end

    $display("Covered %0d lookup beats and %0d fetch beats over %0d register settings.",
             accesses_sent, fetches_sent, settings_used);
    $display("Checked %0d result beats, %0d of them hits and %0d with evictions.",
             beats_checked, hits_seen, evictions_seen);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
